// ===== design/tvhm_pkg.sv =====
// ----------------------------------------------------------------------------
// tvhm_pkg
// shared types and constants of the three-view hit matcher
// ----------------------------------------------------------------------------
`default_nettype none

package tvhm_pkg;

  localparam int ENERGY_W = 16;
  localparam int PLACE_W = 10;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 5;

  localparam int DEF_PEAK_SLOTS = 4;
  localparam int DEF_PLACE_BITS = 10;
  localparam int DEF_SUM_BITS = 12;

  // hit index packing u*16 + v*4 + w
  localparam int U_SHIFT = 4;
  localparam int V_SHIFT = 2;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_SEL_BIT = 2;
  localparam logic REG_WINDOW_LOW = 1'b0;
  localparam logic REG_WINDOW_HIGH = 1'b1;
  localparam int WINDOW_HIGH_RESET = 4095;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy_first;
    logic [PLACE_W-1:0]  place_first;
    logic [ENERGY_W-1:0] energy_second;
    logic [PLACE_W-1:0]  place_second;
    logic [ENERGY_W-1:0] energy_third;
    logic [PLACE_W-1:0]  place_third;
  } tvhm_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  hit_index;
    logic [ENERGY_W-1:0] hit_energy_first;
    logic [ENERGY_W-1:0] hit_energy_second;
    logic [ENERGY_W-1:0] hit_energy_third;
    logic [PLACE_W-1:0]  hit_place_first;
    logic [PLACE_W-1:0]  hit_place_second;
    logic [PLACE_W-1:0]  hit_place_third;
    logic [COUNT_W-1:0]  count_first;
    logic [COUNT_W-1:0]  count_second;
    logic [COUNT_W-1:0]  count_third;
    logic                last_hit;
  } tvhm_out_t;

  typedef struct packed {
    logic load;
    logic clear_counts;
    logic count_step;
    logic emit_step;
  } tvhm_cmd_t;

  typedef struct packed {
    logic load_last;
    logic count_last;
    logic emit_last;
    logic out_free;
  } tvhm_status_t;

endpackage

`default_nettype wire

// ===== design/tvhm_datapath.sv =====
// ----------------------------------------------------------------------------
// tvhm_datapath
// slot storage, per-row window check over lanes, peak counters and hit register
// ----------------------------------------------------------------------------
`default_nettype none

module tvhm_datapath import tvhm_pkg::*; #(
  parameter int PEAK_SLOTS = DEF_PEAK_SLOTS,
  parameter int PLACE_BITS = DEF_PLACE_BITS,
  parameter int SUM_BITS = DEF_SUM_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tvhm_in_t            in_data,
  input  wire tvhm_cmd_t           cmd,
  input  wire logic [SUM_BITS-1:0] window_low,
  input  wire logic [SUM_BITS-1:0] window_high,
  input  wire logic                out_ready,
  output tvhm_status_t             status,
  output logic                     out_valid,
  output tvhm_out_t                out_data
);

  localparam int SLOT_W = $clog2(PEAK_SLOTS);
  localparam int SUMW = PLACE_BITS + 2;
  localparam int CMP_W = (SUMW > SUM_BITS) ? SUMW : SUM_BITS;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PEAK_SLOTS - 1);

  logic [ENERGY_W-1:0]   en_u_r [PEAK_SLOTS];
  logic [ENERGY_W-1:0]   en_v_r [PEAK_SLOTS];
  logic [ENERGY_W-1:0]   en_w_r [PEAK_SLOTS];
  logic [PLACE_BITS-1:0] pl_u_r [PEAK_SLOTS];
  logic [PLACE_BITS-1:0] pl_v_r [PEAK_SLOTS];
  logic [PLACE_BITS-1:0] pl_w_r [PEAK_SLOTS];
  logic [COUNT_W-1:0]    cnt_u_r [PEAK_SLOTS];
  logic [COUNT_W-1:0]    cnt_v_r [PEAK_SLOTS];
  logic [COUNT_W-1:0]    cnt_w_r [PEAK_SLOTS];
  logic [PEAK_SLOTS-1:0] acc_mask_r [PEAK_SLOTS][PEAK_SLOTS];

  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] cu_r, cu_nxt;
  logic [SLOT_W-1:0] cv_r, cv_nxt;
  logic [SLOT_W-1:0] cw_r, cw_nxt;

  logic                  out_valid_r, out_valid_nxt;
  tvhm_out_t             out_data_r;
  tvhm_out_t             hit;
  logic [CMP_W-1:0]      lane_sum [PEAK_SLOTS];
  logic [PEAK_SLOTS-1:0] lane_acc;
  logic [COUNT_W-1:0]    row_cnt;
  logic                  uv_nz;
  logic                  hit_ok;

  // window check for one (u, v) row, one lane per w slot
  always_comb begin
    uv_nz = (en_u_r[cu_r] != '0) && (en_v_r[cv_r] != '0);
    row_cnt = '0;
    for (int j = 0; j < PEAK_SLOTS; j++) begin
      lane_sum[j] = CMP_W'(pl_u_r[cu_r]) + CMP_W'(pl_v_r[cv_r]) + CMP_W'(pl_w_r[j]);
      lane_acc[j] = uv_nz && (en_w_r[j] != '0)
                    && (lane_sum[j] >= CMP_W'(window_low))
                    && (lane_sum[j] <= CMP_W'(window_high));
      row_cnt = row_cnt + COUNT_W'(lane_acc[j]);
    end
  end

  // combination counters
  always_comb begin
    slot_nxt = slot_r;
    cu_nxt = cu_r;
    cv_nxt = cv_r;
    cw_nxt = cw_r;
    if (cmd.load) begin
      slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
    end
    if (cmd.count_step || (cmd.emit_step && cw_r == LAST_SLOT)) begin
      if (cv_r == LAST_SLOT) begin
        cv_nxt = '0;
        cu_nxt = (cu_r == LAST_SLOT) ? '0 : cu_r + 1'b1;
      end else begin
        cv_nxt = cv_r + 1'b1;
      end
    end
    if (cmd.emit_step) begin
      cw_nxt = (cw_r == LAST_SLOT) ? '0 : cw_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      cu_r <= '0;
      cv_r <= '0;
      cw_r <= '0;
    end else begin
      slot_r <= slot_nxt;
      cu_r <= cu_nxt;
      cv_r <= cv_nxt;
      cw_r <= cw_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      en_u_r[slot_r] <= in_data.energy_first;
      en_v_r[slot_r] <= in_data.energy_second;
      en_w_r[slot_r] <= in_data.energy_third;
      pl_u_r[slot_r] <= PLACE_BITS'(in_data.place_first);
      pl_v_r[slot_r] <= PLACE_BITS'(in_data.place_second);
      pl_w_r[slot_r] <= PLACE_BITS'(in_data.place_third);
    end
  end

  // peak use counters and acceptance mask
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_counts) begin
      for (int i = 0; i < PEAK_SLOTS; i++) begin
        cnt_u_r[i] <= '0;
        cnt_v_r[i] <= '0;
        cnt_w_r[i] <= '0;
      end
    end else if (cmd.count_step) begin
      cnt_u_r[cu_r] <= cnt_u_r[cu_r] + row_cnt;
      cnt_v_r[cv_r] <= cnt_v_r[cv_r] + row_cnt;
      for (int j = 0; j < PEAK_SLOTS; j++) begin
        cnt_w_r[j] <= cnt_w_r[j] + COUNT_W'(lane_acc[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.count_step) begin
      acc_mask_r[cu_r][cv_r] <= lane_acc;
    end
  end

  // hit formation
  always_comb begin
    hit_ok = acc_mask_r[cu_r][cv_r][cw_r];
    hit.hit_index = (INDEX_W'(cu_r) << U_SHIFT) | (INDEX_W'(cv_r) << V_SHIFT)
                    | INDEX_W'(cw_r);
    hit.hit_energy_first = hit_ok ? en_u_r[cu_r] : '0;
    hit.hit_energy_second = hit_ok ? en_v_r[cv_r] : '0;
    hit.hit_energy_third = hit_ok ? en_w_r[cw_r] : '0;
    hit.hit_place_first = hit_ok ? PLACE_W'(pl_u_r[cu_r]) : '0;
    hit.hit_place_second = hit_ok ? PLACE_W'(pl_v_r[cv_r]) : '0;
    hit.hit_place_third = hit_ok ? PLACE_W'(pl_w_r[cw_r]) : '0;
    hit.count_first = cnt_u_r[cu_r];
    hit.count_second = cnt_v_r[cv_r];
    hit.count_third = cnt_w_r[cw_r];
    hit.last_hit = (cu_r == LAST_SLOT) && (cv_r == LAST_SLOT) && (cw_r == LAST_SLOT);
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      out_data_r <= hit;
    end
  end

  assign status.load_last = (slot_r == LAST_SLOT);
  assign status.count_last = (cu_r == LAST_SLOT) && (cv_r == LAST_SLOT);
  assign status.emit_last = hit.last_hit;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

`default_nettype wire

// ===== design/tvhm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tvhm_ctrl
// sequencer for slot loading, row counting and hit emission
// ----------------------------------------------------------------------------
`default_nettype none

module tvhm_ctrl import tvhm_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire tvhm_status_t status,
  output logic              in_ready,
  output tvhm_cmd_t         cmd
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_COUNT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    in_ready = (state_r == ST_LOAD);
    cmd.load = in_valid && (state_r == ST_LOAD);
    cmd.clear_counts = cmd.load && status.load_last;
    cmd.count_step = (state_r == ST_COUNT);
    cmd.emit_step = (state_r == ST_EMIT) && status.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (cmd.clear_counts) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (status.count_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cmd.emit_step && status.emit_last) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/three_view_hit_matcher_core.sv =====
// ----------------------------------------------------------------------------
// three_view_hit_matcher_core
// three-view hit matcher: loads PEAK_SLOTS slots per event, checks every
// u/v/w combination against the coordinate window and emits one hit each
// ----------------------------------------------------------------------------
// sequence: after the last slot transaction of an event, the u/v rows are
//   checked, one u/v row of w lanes per cycle, then one hit per cycle is
//   emitted through the output register, held by output stalls; slots are
//   loaded serially, and the next event waits until the last hit is emitted
// reset: synchronous, clears slot pointer, sequencer, counters and low
//   window reg, and sets the high window reg to WINDOW_HIGH_RESET
`default_nettype none

module three_view_hit_matcher_core import tvhm_pkg::*; #(
  parameter int PEAK_SLOTS = DEF_PEAK_SLOTS,
  parameter int PLACE_BITS = DEF_PLACE_BITS,
  parameter int SUM_BITS = DEF_SUM_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire tvhm_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output tvhm_out_t                  out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [SUM_BITS-1:0] window_low_r;
  logic [SUM_BITS-1:0] window_high_r;
  logic                reg_wr;
  logic                reg_sel;
  tvhm_cmd_t           cmd;
  tvhm_status_t        status;

  assign pready = 1'b1;
  assign reg_sel = paddr[REG_SEL_BIT];
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_low_r <= '0;
      window_high_r <= SUM_BITS'(WINDOW_HIGH_RESET);
    end else if (reg_wr) begin
      if (reg_sel == REG_WINDOW_LOW) begin
        window_low_r <= pwdata[SUM_BITS-1:0];
      end else begin
        window_high_r <= pwdata[SUM_BITS-1:0];
      end
    end
  end

  assign prdata = (reg_sel == REG_WINDOW_HIGH) ? APB_DATA_W'(window_high_r)
                                               : APB_DATA_W'(window_low_r);

  tvhm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  tvhm_datapath #(
    .PEAK_SLOTS (PEAK_SLOTS),
    .PLACE_BITS (PLACE_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cmd         (cmd),
    .window_low  (window_low_r),
    .window_high (window_high_r),
    .out_ready   (out_ready),
    .status      (status),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire
